[src/mf3_pkg.sv]
package mf3_pkg;

    // Defaults for the top level parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // Configuration port
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Frame geometry
    localparam int ROW_BITS     = 16;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int MIN_SIZE     = 3;

    // Result slots of one input pixel, in output order
    localparam int NUM_SLOTS = 3;
    localparam int SLOT_A    = 0;   // window center (median or border copy)
    localparam int SLOT_B    = 1;   // right border pixel of the row above
    localparam int SLOT_C    = 2;   // last-row pass-through

endpackage

[src/median3x3_filter.sv]
// 3x3 median filter on a raster-order gray pixel stream.
// Input channel: i_in_valid / o_in_ready with i_pixel_in, one pixel per beat.
// Output channel: o_out_valid / i_out_ready; each beat carries the filtered
// pixel, its column and row, o_last_of_run on the last result of the causing
// input pixel and o_frame_done on the bottom-right pixel of the frame.
// Results trail the input by one row and one column; border pixels pass
// through unchanged, and the right column and the last row are flushed as
// the pixels that complete them arrive.
// The first result of a pixel passes the line store read, the row sort,
// and the median and result register.
// Throughput: one pixel per cycle while the receiver is ready and each
// pixel yields at most one result. The output port moves one result per
// cycle, so on the last row and at row ends input is taken at that pace.
// Sizes are written over i_cfg_we / i_cfg_index / i_cfg_data while idle;
// a write restarts the frame at the next pixel.
// Reset: 640x480, counters at the first pixel of a frame, pipeline empty.
// The line stores get no clearing pass: no value read before the current
// frame has written its entry reaches a result.
// A stalled receiver holds the result register; S1 and S2 keep filling
// and o_in_ready drops once both of them hold a pixel.
module median3x3_filter #(
    parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [mf3_pkg::CFG_ADDR_BITS-1:0]  i_cfg_index,
    input  logic [mf3_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // pixel input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [PIXEL_BITS-1:0]              i_pixel_in,
    // result output
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [PIXEL_BITS-1:0]              o_pixel_out,
    output logic [CW-1:0]                      o_out_column,
    output logic [mf3_pkg::ROW_BITS-1:0]       o_out_row,
    output logic                               o_last_of_run,
    output logic                               o_frame_done
);

    localparam int PB = PIXEL_BITS;
    localparam int RB = mf3_pkg::ROW_BITS;
    localparam int WW = CW + 1;
    localparam int NS = mf3_pkg::NUM_SLOTS;
    localparam int W_RST = (mf3_pkg::WIDTH_RESET > MAX_WIDTH) ?
                           MAX_WIDTH : mf3_pkg::WIDTH_RESET;
    localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);
    localparam logic [WW-1:0] W_MIN = WW'(mf3_pkg::MIN_SIZE);
    localparam logic [RB-1:0] H_MIN = RB'(mf3_pkg::MIN_SIZE);

    // Sort three pixels, returned as {hi, mid, lo}
    function automatic logic [3*PB-1:0] sort3(
        input logic [PB-1:0] a,
        input logic [PB-1:0] b,
        input logic [PB-1:0] c
    );
        logic [PB-1:0] l0, h0, m1, h1, l2, m2;
        begin
            l0 = (a < b) ? a : b;
            h0 = (a < b) ? b : a;
            m1 = (h0 < c) ? h0 : c;
            h1 = (h0 < c) ? c : h0;
            l2 = (l0 < m1) ? l0 : m1;
            m2 = (l0 < m1) ? m1 : l0;
            return {h1, m2, l2};
        end
    endfunction

    // ------------------------------------------------------------------
    // Size registers, kept as effective size minus one
    // ------------------------------------------------------------------
    logic [CW-1:0]  r_wm1, n_wm1;
    logic [RB-1:0]  r_hm1, n_hm1;
    logic [WW-1:0]  cfg_w;
    logic [RB-1:0]  cfg_h;
    logic           cfg_hit;

    always_comb begin
        cfg_w = i_cfg_data[WW-1:0];
        if (cfg_w < W_MIN) begin
            cfg_w = W_MIN;
        end else if (cfg_w > W_MAX) begin
            cfg_w = W_MAX;
        end
        cfg_h = i_cfg_data[RB-1:0];
        if (cfg_h < H_MIN) begin
            cfg_h = H_MIN;
        end
        n_wm1   = r_wm1;
        n_hm1   = r_hm1;
        cfg_hit = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                mf3_pkg::REG_IMAGE_WIDTH: begin
                    n_wm1   = CW'(cfg_w - 1'b1);
                    cfg_hit = 1'b1;
                end
                mf3_pkg::REG_IMAGE_HEIGHT: begin
                    n_hm1   = cfg_h - 1'b1;
                    cfg_hit = 1'b1;
                end
                default: cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1 <= CW'(W_RST - 1);
            r_hm1 <= RB'(mf3_pkg::HEIGHT_RESET - 1);
        end else begin
            r_wm1 <= n_wm1;
            r_hm1 <= n_hm1;
        end
    end

    // ------------------------------------------------------------------
    // Handshake chain: input -> S1 -> S2 -> result register
    // ------------------------------------------------------------------
    logic           r1_vld, r2_vld;
    logic [NS-1:0]  r_g_mask;
    logic [NS-1:0]  g_sel;
    logic [NS-1:0]  g_rest;
    logic           out_fire, g_ready, s2_ready, s1_ready;
    logic           s1_adv, s2_adv, in_fire;

    // pick the lowest pending slot
    assign g_sel    = r_g_mask & (~r_g_mask + 1'b1);
    assign g_rest   = r_g_mask & ~g_sel;
    assign out_fire = o_out_valid && i_out_ready;
    assign g_ready  = (r_g_mask == '0) || (out_fire && (g_rest == '0));
    assign s2_ready = !r2_vld || g_ready;
    assign s1_ready = !r1_vld || s2_ready;
    assign s2_adv   = r2_vld && g_ready;
    assign s1_adv   = r1_vld && s2_ready;
    assign in_fire  = i_in_valid && s1_ready;
    assign o_in_ready = s1_ready;

    // ------------------------------------------------------------------
    // Stage 0: column/row counters, line store read
    // ------------------------------------------------------------------
    logic [CW-1:0]  r_col;
    logic [RB-1:0]  r_row;
    logic           col_end, row_end;

    assign col_end = (r_col == r_wm1);
    assign row_end = (r_row == r_hm1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : RB'(r_row + 1'b1);
            end else begin
                r_col <= CW'(r_col + 1'b1);
            end
        end
    end

    // Stage 1 registers: pixel, position and which results it causes
    logic [PB-1:0]  r1_pix;
    logic [CW-1:0]  r1_x;
    logic [RB-1:0]  r1_y;
    logic           r1_inner, r1_done;
    logic [NS-1:0]  r1_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (s1_ready) begin
            r1_vld <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r1_pix   <= i_pixel_in;
            r1_x     <= r_col;
            r1_y     <= r_row;
            r1_inner <= (r_col >= CW'(2)) && (r_row >= RB'(2));
            r1_done  <= col_end;
            r1_mask[mf3_pkg::SLOT_A] <= (r_row != '0) && (r_col != '0);
            r1_mask[mf3_pkg::SLOT_B] <= (r_row != '0) && col_end;
            r1_mask[mf3_pkg::SLOT_C] <= row_end;
        end
    end

    // Line stores: read at stage 0, written back as the pixel leaves S1.
    // Neighboring pixels always touch different columns, so a read never
    // meets a pending write to the same entry.
    logic [PB-1:0]  older_rd, newer_rd;

    mf3_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WIDTH)
    ) u_older_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r1_x),
        .i_wdata (newer_rd),
        .i_re    (in_fire),
        .i_raddr (r_col),
        .o_rdata (older_rd)
    );

    mf3_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WIDTH)
    ) u_newer_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r1_x),
        .i_wdata (r1_pix),
        .i_re    (in_fire),
        .i_raddr (r_col),
        .o_rdata (newer_rd)
    );

    // ------------------------------------------------------------------
    // Stage 1: window shift and row sort
    // ------------------------------------------------------------------
    logic [PB-1:0]  r_win [9];
    logic [PB-1:0]  n_win [9];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]     = r_win[r*3+1];
            n_win[r*3 + 1] = r_win[r*3+2];
        end
        n_win[2] = older_rd;
        n_win[5] = newer_rd;
        n_win[8] = r1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (s1_adv) begin
            r_win <= n_win;
        end
    end

    // Stage 2 registers
    logic [2:0][PB-1:0] r2_lo, r2_mid, r2_hi;
    logic [PB-1:0]  r2_ctr, r2_b, r2_c;
    logic [CW-1:0]  r2_x;
    logic [RB-1:0]  r2_y;
    logic           r2_inner, r2_done;
    logic [NS-1:0]  r2_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (s2_ready) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            for (int r = 0; r < 3; r++) begin
                {r2_hi[r], r2_mid[r], r2_lo[r]} <=
                    sort3(n_win[r*3], n_win[r*3+1], n_win[r*3+2]);
            end
            r2_ctr   <= n_win[4];
            r2_b     <= n_win[5];
            r2_c     <= r1_pix;
            r2_x     <= r1_x;
            r2_y     <= r1_y;
            r2_inner <= r1_inner;
            r2_done  <= r1_done;
            r2_mask  <= r1_mask;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: median, into the result register
    // ------------------------------------------------------------------
    logic [PB-1:0]  med;

    mf3_median #(
        .PIXEL_BITS (PB)
    ) u_median (
        .i_lo  (r2_lo),
        .i_mid (r2_mid),
        .i_hi  (r2_hi),
        .o_med (med)
    );

    logic [PB-1:0]  r_g_a, r_g_b, r_g_c;
    logic [CW-1:0]  r_g_x;
    logic [RB-1:0]  r_g_y;
    logic           r_g_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_mask <= '0;
        end else if (s2_adv) begin
            r_g_mask <= r2_mask;
        end else if (out_fire) begin
            r_g_mask <= g_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_g_a    <= r2_inner ? med : r2_ctr;
            r_g_b    <= r2_b;
            r_g_c    <= r2_c;
            r_g_x    <= r2_x;
            r_g_y    <= r2_y;
            r_g_done <= r2_done;
        end
    end

    // ------------------------------------------------------------------
    // Output: one pending slot per beat, lowest first
    // ------------------------------------------------------------------
    assign o_out_valid   = (r_g_mask != '0);
    assign o_last_of_run = (g_rest == '0);

    always_comb begin
        o_pixel_out  = r_g_c;
        o_out_column = r_g_x;
        o_out_row    = r_g_y;
        o_frame_done = 1'b0;
        if (g_sel[mf3_pkg::SLOT_A]) begin
            o_pixel_out  = r_g_a;
            o_out_column = CW'(r_g_x - 1'b1);
            o_out_row    = RB'(r_g_y - 1'b1);
        end else if (g_sel[mf3_pkg::SLOT_B]) begin
            o_pixel_out  = r_g_b;
            o_out_row    = RB'(r_g_y - 1'b1);
        end else begin
            o_frame_done = r_g_done;
        end
    end

endmodule

[src/mf3_ram.sv]
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/mf3_median.sv]
module mf3_median #(
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
    input  logic [2:0][PIXEL_BITS-1:0] i_lo,   // smallest of each window row
    input  logic [2:0][PIXEL_BITS-1:0] i_mid,  // middle of each window row
    input  logic [2:0][PIXEL_BITS-1:0] i_hi,   // largest of each window row
    output logic [PIXEL_BITS-1:0]      o_med
);

    function automatic logic [PIXEL_BITS-1:0] max2(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b
    );
        return (a < b) ? b : a;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] min2(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] med3(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b,
        input logic [PIXEL_BITS-1:0] c
    );
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic [PIXEL_BITS-1:0] lo_max;
    logic [PIXEL_BITS-1:0] mid_med;
    logic [PIXEL_BITS-1:0] hi_min;

    // With rows sorted, the median of nine is the median of these three
    assign lo_max  = max2(max2(i_lo[0], i_lo[1]), i_lo[2]);
    assign mid_med = med3(i_mid[0], i_mid[1], i_mid[2]);
    assign hi_min  = min2(min2(i_hi[0], i_hi[1]), i_hi[2]);
    assign o_med   = med3(lo_max, mid_med, hi_min);

endmodule

[tb/testbench.sv]
module testbench;

    localparam int CW           = $clog2(mf3_pkg::MAX_WIDTH_DEF);
    localparam int RB           = mf3_pkg::ROW_BITS;
    localparam int MAXW         = mf3_pkg::MAX_WIDTH_DEF;
    localparam int MINS         = mf3_pkg::MIN_SIZE;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int SETTLE       = 16;    // cycles past the last result before a size write
    localparam int RANDOM_ITEMS = 40;

    // One filtered pixel as seen on the output channel
    typedef struct packed {
        logic [7:0]    pix;
        logic [CW-1:0] col;
        logic [RB-1:0] row;
        logic          last;
        logic          done;
    } t_filt_result;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [mf3_pkg::CFG_ADDR_BITS-1:0]    cfg_index = '0;
    logic [mf3_pkg::CFG_DATA_BITS-1:0]    cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 o_in_ready;
    logic [7:0]                           pixel_in = '0;
    logic                                 o_out_valid;
    logic                                 out_ready = 1'b0;
    logic [7:0]                           o_pixel_out;
    logic [CW-1:0]                        o_out_column;
    logic [RB-1:0]                        o_out_row;
    logic                                 o_last_of_run;
    logic                                 o_frame_done;

    median3x3_filter u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel_in   (pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_pixel_out  (o_pixel_out),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_last_of_run(o_last_of_run),
        .o_frame_done (o_frame_done)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Filter state mirrored by the predictor
    logic [10:0]          width_reg;
    logic [15:0]          height_reg;
    logic [7:0]           line_old [MAXW];
    logic [7:0]           line_new [MAXW];
    logic [7:0]           win [9];
    int                   col_cnt;
    int                   row_cnt;

    t_filt_result         pending_results [$];
    int                   err_count = 0;
    int                   cycle_count = 0;
    int                   burst_left = 0;

    // Fifth smallest of the nine window pixels
    function automatic logic [7:0] rank_median();
        int below, upto;
        for (int i = 0; i < 9; i++) begin
            below = 0;
            upto  = 0;
            for (int j = 0; j < 9; j++) begin
                if (win[j] < win[i]) below++;
                if (win[j] <= win[i]) upto++;
            end
            if (below <= 4 && 4 < upto) return win[i];
        end
        return win[4];
    endfunction

    // Advance the mirrored filter by one pixel and queue the results it causes
    task automatic predict_filter(input logic [7:0] p);
        int w, h, x, y, xi, n, cx, cy;
        bit interior;
        t_filt_result res [3];
        w = int'(width_reg);
        if (w < MINS) w = MINS;
        if (w > MAXW) w = MAXW;
        h = int'(height_reg);
        if (h < MINS) h = MINS;
        x = col_cnt;
        y = row_cnt;
        if (x >= w) x = w - 1;
        if (y >= h) y = h - 1;
        xi = x % MAXW;

        // shift window left, new column from the line stores and the pixel
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = line_old[xi];
        win[5] = line_new[xi];
        win[8] = p;
        line_old[xi] = line_new[xi];
        line_new[xi] = p;

        n = 0;
        if (y >= 1) begin
            if (x >= 1) begin
                cx = x - 1;
                cy = y - 1;
                interior = cx >= 1 && cx <= w - 2 && cy >= 1 && cy <= h - 2;
                res[n] = '{pix: interior ? rank_median() : win[4], col: CW'(cx),
                           row: RB'(cy), last: 1'b0, done: 1'b0};
                n++;
            end
            if (x == w - 1) begin
                res[n] = '{pix: win[5], col: CW'(w - 1), row: RB'(y - 1),
                           last: 1'b0, done: 1'b0};
                n++;
            end
        end
        // last row passes straight through
        if (y == h - 1) begin
            res[n] = '{pix: p, col: CW'(x), row: RB'(y), last: 1'b0,
                       done: (x == w - 1)};
            n++;
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_results.push_back(res[i]);

        if (x >= w - 1) begin
            col_cnt = 0;
            row_cnt = (y >= h - 1) ? 0 : y + 1;
        end else begin
            col_cnt = x + 1;
            row_cnt = y;
        end
    endtask

    // Send one pixel beat; bursts with random gaps in between
    task automatic send_pixel(input logic [7:0] p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge clk) in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        pixel_in <= p;
        do @(posedge clk); while (!o_in_ready);
        predict_filter(p);
        burst_left--;
    endtask

    // Stop sending and wait until every queued result has come out
    task automatic wait_results_drained(input int settle);
        @(negedge clk) in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Size register write; a write restarts the frame
    task automatic write_size_reg(input logic [mf3_pkg::CFG_ADDR_BITS-1:0] idx,
                                  input logic [mf3_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk) cfg_we <= 1'b0;
        if (idx == mf3_pkg::REG_IMAGE_WIDTH) width_reg = data[10:0];
        else height_reg = data;
        col_cnt = 0;
        row_cnt = 0;
    endtask

    function automatic logic [7:0] rand_pixel(input int mode);
        case (mode)
            0: return 8'($urandom);
            1: return 8'($urandom_range(0, 3));
            2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: return 8'(100 + $urandom_range(0, 2));
        endcase
    endfunction

    // Smallest frame: every slot, right border, last row, frame end
    task automatic test_min_frame();
        logic [7:0] pix [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                                8'd0, 8'd255, 8'd128};
        wait_results_drained(SETTLE);
        write_size_reg(mf3_pkg::REG_IMAGE_WIDTH, 16'd3);
        write_size_reg(mf3_pkg::REG_IMAGE_HEIGHT, 16'd3);
        foreach (pix[i]) send_pixel(pix[i]);
    endtask

    // Sizes below the minimum clamp to 3; width bits above bit 10 are dropped
    task automatic test_clamped_sizes();
        logic [7:0] pix [9] = '{8'd7, 8'd7, 8'd7, 8'd3, 8'd7, 8'd9,
                                8'd9, 8'd3, 8'd3};
        wait_results_drained(SETTLE);
        write_size_reg(mf3_pkg::REG_IMAGE_WIDTH, 16'hF802);
        write_size_reg(mf3_pkg::REG_IMAGE_HEIGHT, 16'h0000);
        foreach (pix[i]) send_pixel(pix[i]);
    endtask

    // Sender holds off mid-frame until the output side has caught up
    task automatic test_pause_midframe();
        wait_results_drained(SETTLE);
        write_size_reg(mf3_pkg::REG_IMAGE_WIDTH, 16'd5);
        write_size_reg(mf3_pkg::REG_IMAGE_HEIGHT, 16'd4);
        repeat (10) send_pixel(rand_pixel(0));
        wait_results_drained(0);
        repeat (10) send_pixel(rand_pixel(0));
    endtask

    // Small random frames, back-to-back frames and cut-off frames
    task automatic test_random_frames();
        int sent, w, h, npix, mode;
        logic [10:0] wval;
        logic [15:0] hval;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 16)
                                            : $urandom_range(3, 6);
            h = $urandom_range(3, 5);
            wval = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2)) : 11'(w);
            hval = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2)) : 16'(h);
            if (wval < MINS) w = MINS;
            if (hval < MINS) h = MINS;
            mode = $urandom_range(0, 3);
            wait_results_drained(SETTLE);
            write_size_reg(mf3_pkg::REG_IMAGE_WIDTH, {5'($urandom), wval});
            write_size_reg(mf3_pkg::REG_IMAGE_HEIGHT, hval);
            npix = w * h * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) npix = $urandom_range(1, w * h - 1);
            if (npix > RANDOM_ITEMS - sent) npix = RANDOM_ITEMS - sent;
            repeat (npix) send_pixel(rand_pixel(mode));
            sent += npix;
        end
    endtask

    // Widest and tallest setting: the top row gives nothing; then a narrow,
    // very tall frame where the last row is never reached
    task automatic test_max_sizes();
        wait_results_drained(SETTLE);
        write_size_reg(mf3_pkg::REG_IMAGE_WIDTH, 16'hFFFF);
        write_size_reg(mf3_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
        repeat (12) send_pixel(rand_pixel(0));
        wait_results_drained(SETTLE);
        write_size_reg(mf3_pkg::REG_IMAGE_WIDTH, 16'd3);
        repeat (24) send_pixel(rand_pixel(0));
    endtask

    // Receiver ready pattern: one of four modes, picked anew at random
    int ready_mode = 0;
    int mode_left = 0;
    int stall_left = 0;
    int ready_tick = 0;
    always @(negedge clk) begin
        ready_tick++;
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 100);
        end else begin
            mode_left--;
        end
        if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= (ready_tick % 3 == 0);
                default: begin
                    if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 20);
                    out_ready <= (stall_left == 0);
                end
            endcase
        end
    end

    // Compare each output beat with the oldest expectation
    always @(posedge clk) begin
        t_filt_result want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result: pix=%0d col=%0d row=%0d last=%0d done=%0d",
                             o_pixel_out, o_out_column, o_out_row, o_last_of_run,
                             o_frame_done);
            end else begin
                want = pending_results.pop_front();
                if (o_pixel_out !== want.pix || o_out_column !== want.col ||
                    o_out_row !== want.row || o_last_of_run !== want.last ||
                    o_frame_done !== want.done) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("mismatch: exp pix=%0d col=%0d row=%0d last=%0d done=%0d",
                                 want.pix, want.col, want.row, want.last, want.done);
                        $display("          got pix=%0d col=%0d row=%0d last=%0d done=%0d",
                                 o_pixel_out, o_out_column, o_out_row, o_last_of_run,
                                 o_frame_done);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        width_reg  = 11'(mf3_pkg::WIDTH_RESET);
        height_reg = 16'(mf3_pkg::HEIGHT_RESET);
        foreach (line_old[i]) begin
            line_old[i] = '0;
            line_new[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
        col_cnt = 0;
        row_cnt = 0;

        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_min_frame();
        test_clamped_sizes();
        test_pause_midframe();
        test_random_frames();
        test_max_sizes();

        wait_results_drained(SETTLE);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[sim.f]
src/mf3_pkg.sv
src/mf3_ram.sv
src/mf3_median.sv
src/median3x3_filter.sv
tb/testbench.sv
